FILE: design/lfs_pkg.sv
`default_nettype none
package lfs_pkg;

    typedef enum logic [2:0] {
        MODE_STOP        = 3'd0,
        MODE_STRAIGHT    = 3'd1,
        MODE_TURN_RIGHT  = 3'd2,
        MODE_TURN_LEFT   = 3'd3,
        MODE_PIVOT_RIGHT = 3'd4,
        MODE_PIVOT_LEFT  = 3'd5
    } t_mode;

    typedef enum logic {
        REG_AMBIENT_LEVEL = 1'b0,
        REG_LEFT_OFFSET   = 1'b1
    } t_reg_index;

    localparam int LIGHT_W  = 8;
    localparam int DUTY_W   = 7;
    localparam int SP_NUM_W = 14;   // (x - ambient) * 40 stays below 2^14
    localparam int TN_NUM_W = 13;   // diff * 20 stays below 2^13
    localparam int SP_QUO_W = 6;    // speed quotient is at most 40
    localparam int TN_QUO_W = 5;    // turn quotient is at most 20

    localparam logic [LIGHT_W-1:0] TOL_AMBIENT   = 8'd20;
    localparam logic [LIGHT_W-1:0] TOL_STRAIGHT  = 8'd10;
    localparam logic [LIGHT_W-1:0] LIGHT_MAX     = 8'hFF;
    localparam logic [DUTY_W-1:0]  DUTY_PIVOT    = 7'd50;
    localparam logic [DUTY_W-1:0]  DUTY_NORMAL   = 7'd30;
    localparam logic [DUTY_W-1:0]  STRAIGHT_TRIM = 7'd2;
    localparam logic [5:0]         SPEED_GAIN    = 6'd40;   // 70 - 30
    localparam logic [4:0]         TURN_GAIN     = 5'd20;   // 30 - 10

    // word carried through the divider stages
    typedef struct packed {
        t_mode                mode;
        logic [LIGHT_W-1:0]   span;
        logic [SP_NUM_W-1:0]  sp_rem;
        logic [TN_NUM_W-1:0]  tn_rem;
        logic [SP_QUO_W-1:0]  sp_quo;
        logic [TN_QUO_W-1:0]  tn_quo;
    } t_div_word;

endpackage
`default_nettype wire

FILE: design/lfs_front.sv
`default_nettype none
module lfs_front
    import lfs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [LIGHT_W-1:0]   i_ambient,
    input  wire logic [LIGHT_W-1:0]   i_offset,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [LIGHT_W-1:0]   i_right,
    input  wire logic [LIGHT_W-1:0]   i_left,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_div_word                 o_word
);

    typedef struct packed {
        t_mode              mode;
        logic [LIGHT_W-1:0] span;
        logic [LIGHT_W-1:0] xa;
        logic [LIGHT_W-1:0] diff;
    } t_decide_word;

    logic               w_ready_b;
    logic [LIGHT_W-1:0] w_lsum, w_rc, w_lc, w_diff, w_arg;
    logic               w_rb, w_straight, w_pivot, w_stop;
    t_decide_word       n_dec;
    t_decide_word       r_dec;
    logic               r_dec_valid;
    t_div_word          n_word;
    t_div_word          r_word;
    logic               r_word_valid;

    // stage a: offset, clamp, mode decision
    always_comb begin
        w_lsum     = i_left + i_offset;
        w_rc       = (i_right < i_ambient) ? i_ambient : i_right;
        w_lc       = (w_lsum < i_ambient) ? i_ambient : w_lsum;
        w_rb       = w_rc > w_lc;
        w_diff     = w_rb ? (w_rc - w_lc) : (w_lc - w_rc);
        w_straight = w_diff < TOL_STRAIGHT;
        w_pivot    = w_rb ? (w_lc <= i_ambient) : (w_rc <= i_ambient);
        w_stop     = ({1'b0, w_rc} < ({1'b0, i_ambient} + {1'b0, TOL_AMBIENT}))
                  && ({1'b0, w_lc} < ({1'b0, i_ambient} + {1'b0, TOL_AMBIENT}));
        priority if (w_stop) begin
            n_dec.mode = MODE_STOP;
        end else if (w_straight) begin
            n_dec.mode = MODE_STRAIGHT;
        end else if (w_rb && !w_pivot) begin
            n_dec.mode = MODE_TURN_RIGHT;
        end else if (!w_rb && !w_pivot) begin
            n_dec.mode = MODE_TURN_LEFT;
        end else if (w_rb) begin
            n_dec.mode = MODE_PIVOT_RIGHT;
        end else begin
            n_dec.mode = MODE_PIVOT_LEFT;
        end
        // only turn left drives from the left reading
        w_arg      = (n_dec.mode == MODE_TURN_LEFT) ? w_lc : w_rc;
        n_dec.xa   = w_arg - i_ambient;
        n_dec.diff = w_diff;
        n_dec.span = LIGHT_MAX - i_ambient;
    end

    assign o_ready = !r_dec_valid || w_ready_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (o_ready) begin
            r_dec_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    // stage b: scale numerators by constant gains
    always_comb begin
        n_word.mode   = r_dec.mode;
        n_word.span   = r_dec.span;
        n_word.sp_rem = SP_NUM_W'(r_dec.xa) * SP_NUM_W'(SPEED_GAIN);
        n_word.tn_rem = TN_NUM_W'(r_dec.diff) * TN_NUM_W'(TURN_GAIN);
        n_word.sp_quo = '0;
        n_word.tn_quo = '0;
    end

    assign w_ready_b = !r_word_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= 1'b0;
        end else if (w_ready_b) begin
            r_word_valid <= r_dec_valid;
        end
        if (w_ready_b && r_dec_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_word_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

FILE: design/lfs_div_stage.sv
`default_nettype none
module lfs_div_stage
    import lfs_pkg::*;
#(
    parameter int BIT = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_word i_word,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_word      o_word
);

    logic [SP_NUM_W:0]   w_sp_den;
    logic [SP_NUM_W:0]   w_sp_rem;
    logic [TN_NUM_W-1:0] w_tn_rem_nx;
    logic [TN_QUO_W-1:0] w_tn_quo_nx;
    t_div_word           n_word;
    t_div_word           r_word;
    logic                r_valid;

    // one restoring step per quotient bit, both divisions share the span
    always_comb begin
        w_sp_den = (SP_NUM_W + 1)'(i_word.span) << BIT;
        w_sp_rem = (SP_NUM_W + 1)'(i_word.sp_rem);
        n_word   = i_word;
        if (w_sp_rem >= w_sp_den) begin
            n_word.sp_rem      = SP_NUM_W'(w_sp_rem - w_sp_den);
            n_word.sp_quo[BIT] = 1'b1;
        end
        n_word.tn_rem = w_tn_rem_nx;
        n_word.tn_quo = w_tn_quo_nx;
    end

    generate
        if (BIT < TN_QUO_W) begin : g_turn
            logic [TN_NUM_W:0] w_tn_den;
            logic [TN_NUM_W:0] w_tn_rem;
            logic              w_tn_take;
            assign w_tn_den  = (TN_NUM_W + 1)'(i_word.span) << BIT;
            assign w_tn_rem  = (TN_NUM_W + 1)'(i_word.tn_rem);
            assign w_tn_take = w_tn_rem >= w_tn_den;
            always_comb begin
                w_tn_rem_nx      = w_tn_take ? TN_NUM_W'(w_tn_rem - w_tn_den)
                                             : i_word.tn_rem;
                w_tn_quo_nx      = i_word.tn_quo;
                w_tn_quo_nx[BIT] = w_tn_take;
            end
        end else begin : g_no_turn
            assign w_tn_rem_nx = i_word.tn_rem;
            assign w_tn_quo_nx = i_word.tn_quo;
        end
    endgenerate

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

FILE: design/lfs_back.sv
`default_nettype none
module lfs_back
    import lfs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_word i_word,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic [23:0]    o_data
);

    logic [DUTY_W-1:0] w_speed, w_turn;
    logic [DUTY_W-1:0] n_ld, n_rd;
    logic              n_lrev, n_rrev;
    t_mode             r_mode;
    logic [DUTY_W-1:0] r_ld, r_rd;
    logic              r_lrev, r_rrev;
    logic              r_valid;

    always_comb begin
        w_speed = DUTY_W'(i_word.sp_quo) + DUTY_NORMAL;
        w_turn  = DUTY_NORMAL - DUTY_W'(i_word.tn_quo);
        n_ld    = '0;
        n_rd    = '0;
        n_lrev  = 1'b0;
        n_rrev  = 1'b0;
        unique case (i_word.mode)
            MODE_STRAIGHT: begin
                n_ld = w_speed;
                n_rd = w_speed + STRAIGHT_TRIM;
            end
            MODE_TURN_RIGHT: begin
                n_ld = w_speed;
                n_rd = w_turn;
            end
            MODE_TURN_LEFT: begin
                n_ld = w_turn;
                n_rd = w_speed;
            end
            MODE_PIVOT_RIGHT: begin
                n_ld   = DUTY_PIVOT;
                n_rd   = DUTY_PIVOT;
                n_rrev = 1'b1;
            end
            MODE_PIVOT_LEFT: begin
                n_ld   = DUTY_PIVOT;
                n_rd   = DUTY_PIVOT;
                n_lrev = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_mode <= i_word.mode;
            r_ld   <= n_ld;
            r_rd   <= n_rd;
            r_lrev <= n_lrev;
            r_rrev <= n_rrev;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {5'b0, r_rrev, r_lrev, r_rd, r_ld, r_mode};

endmodule
`default_nettype wire

FILE: design/light_follow_steering.sv
// Steering decision for a light-following robot: each input word carries a right and a left
// light reading and yields one output word with the drive mode, both wheel duties and both
// reverse flags. An item enters every cycle unless backpressure holds the input; it passes two
// front stages for clamping, mode choice and gain scaling, six stages of a restoring divider
// that each yield one quotient bit of the speed term and, all but the first, of the turn term,
// and one output register. Backpressure on the output stalls only the stages that are full.
// Configuration writes take effect immediately and belong in idle periods: index 0 is the
// ambient level, index 1 the left offset; writes are always ready.
`default_nettype none
module light_follow_steering
    import lfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,    // right_light[7:0], left_light[15:8]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,    // drive_mode[2:0], left_duty[9:3], right_duty[16:10],
                                           // left_reverse[17], right_reverse[18], zero fill
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int NUM_DIV = SP_QUO_W;

    logic [LIGHT_W-1:0] r_ambient;
    logic [LIGHT_W-1:0] r_offset;

    logic      w_valid [NUM_DIV+1];
    logic      w_ready [NUM_DIV+1];
    t_div_word w_word  [NUM_DIV+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient <= '0;
            r_offset  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_addr))
                REG_AMBIENT_LEVEL: r_ambient <= i_cfg_data;
                REG_LEFT_OFFSET:   r_offset  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lfs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ambient (r_ambient),
        .i_offset  (r_offset),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_right   (i_s_tdata[7:0]),
        .i_left    (i_s_tdata[15:8]),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_word    (w_word[0])
    );

    // quotient bits from most significant down
    generate
        for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
            lfs_div_stage #(
                .BIT (NUM_DIV - 1 - g)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_word  (w_word[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_word  (w_word[g+1])
            );
        end
    endgenerate

    lfs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_DIV]),
        .o_ready (w_ready[NUM_DIV]),
        .i_word  (w_word[NUM_DIV]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule
`default_nettype wire

FILE: dv/light_follow_steering_tb.sv
`timescale 1ns / 100ps
module light_follow_steering_tb;
    import lfs_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int AMB_MARGIN    = 20;
    localparam int STRAIGHT_BAND = 10;
    localparam int BASE_DUTY     = 30;
    localparam int SPEED_RANGE   = 40;
    localparam int TURN_RANGE    = 20;
    localparam int PIVOT_DUTY    = 50;
    localparam int TRIM_DUTY     = 2;
    localparam int FULL_SCALE    = 255;

    typedef struct packed {
        t_mode      mode;
        logic [6:0] left_duty;
        logic [6:0] right_duty;
        logic       left_rev;
        logic       right_rev;
    } t_steer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;    // right_light[7:0], left_light[15:8]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;    // drive_mode[2:0], left_duty[9:3], right_duty[16:10],
                               // left_reverse[17], right_reverse[18], zero fill
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_data;

    t_steer     steer_q[$];
    logic [7:0] ambient_q;
    logic [7:0] offset_q;
    int         fail_count;
    int         cycle_count = 0;
    int         rx_hold_len;
    bit         tx_idle_en;
    bit         rx_idle_en;

    light_follow_steering u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int drive_duty(input int x);
        int span;
        span = FULL_SCALE - ambient_q;
        if (span == 0 || x < ambient_q) begin
            return BASE_DUTY;
        end
        return (x - ambient_q) * SPEED_RANGE / span + BASE_DUTY;
    endfunction

    function automatic int turn_duty(input int diff);
        int span;
        int drop;
        span = FULL_SCALE - ambient_q;
        if (span == 0) begin
            return BASE_DUTY;
        end
        drop = diff * TURN_RANGE / span;
        return (drop > BASE_DUTY) ? 0 : BASE_DUTY - drop;
    endfunction

    function automatic t_steer predict_steer(input logic [7:0] right_raw, input logic [7:0] left_raw);
        t_steer     s;
        logic [7:0] left_sum;
        int         a;
        int         r;
        int         l;
        int         diff;
        bit         r_brighter;
        bit         pivot;
        a        = ambient_q;
        left_sum = left_raw + offset_q;    // wraps before the clamp
        r        = (right_raw < ambient_q) ? a : right_raw;
        l        = (left_sum < ambient_q) ? a : left_sum;
        r_brighter = r > l;
        diff       = r_brighter ? r - l : l - r;
        pivot      = r_brighter ? (l <= a) : (r <= a);
        s = '0;
        s.mode = MODE_STOP;
        if (r < a + AMB_MARGIN && l < a + AMB_MARGIN) begin
            s.mode = MODE_STOP;
        end else if (diff < STRAIGHT_BAND) begin
            s.mode       = MODE_STRAIGHT;
            s.left_duty  = 7'(drive_duty(r));
            s.right_duty = 7'(drive_duty(r) + TRIM_DUTY);
        end else if (!pivot && r_brighter) begin
            s.mode       = MODE_TURN_RIGHT;
            s.left_duty  = 7'(drive_duty(r));
            s.right_duty = 7'(turn_duty(diff));
        end else if (!pivot) begin
            s.mode       = MODE_TURN_LEFT;
            s.right_duty = 7'(drive_duty(l));
            s.left_duty  = 7'(turn_duty(diff));
        end else if (r_brighter) begin
            s.mode       = MODE_PIVOT_RIGHT;
            s.left_duty  = 7'(PIVOT_DUTY);
            s.right_duty = 7'(PIVOT_DUTY);
            s.right_rev  = 1'b1;
        end else begin
            s.mode       = MODE_PIVOT_LEFT;
            s.left_duty  = 7'(PIVOT_DUTY);
            s.right_duty = 7'(PIVOT_DUTY);
            s.left_rev   = 1'b1;
        end
        return s;
    endfunction

    // one process sees every handshake, so the order of compare, push and
    // register update never depends on the scheduler
    always @(posedge i_clk) begin
        t_steer got;
        t_steer want;
        if (!i_rst_n) begin
            ambient_q = '0;
            offset_q  = '0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.mode       = t_mode'(o_m_tdata[2:0]);
                got.left_duty  = o_m_tdata[9:3];
                got.right_duty = o_m_tdata[16:10];
                got.left_rev   = o_m_tdata[17];
                got.right_rev  = o_m_tdata[18];
                if (steer_q.size() == 0) begin
                    $error("result word 0x%h with no pending expectation", o_m_tdata);
                    fail_count++;
                end else begin
                    want = steer_q.pop_front();
                    if (got.mode !== want.mode) begin
                        $error("drive_mode: expected %0d, got %0d", want.mode, got.mode);
                        fail_count++;
                    end
                    if (got.left_duty !== want.left_duty) begin
                        $error("left_duty: expected %0d, got %0d", want.left_duty,
                               got.left_duty);
                        fail_count++;
                    end
                    if (got.right_duty !== want.right_duty) begin
                        $error("right_duty: expected %0d, got %0d", want.right_duty,
                               got.right_duty);
                        fail_count++;
                    end
                    if (got.left_rev !== want.left_rev) begin
                        $error("left_reverse: expected %0d, got %0d", want.left_rev,
                               got.left_rev);
                        fail_count++;
                    end
                    if (got.right_rev !== want.right_rev) begin
                        $error("right_reverse: expected %0d, got %0d", want.right_rev,
                               got.right_rev);
                        fail_count++;
                    end
                    if (o_m_tdata[23:19] !== '0) begin
                        $error("zero fill: expected 0, got 0x%h", o_m_tdata[23:19]);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                steer_q.push_back(predict_steer(i_s_tdata[7:0], i_s_tdata[15:8]));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (t_reg_index'(i_cfg_addr) == REG_AMBIENT_LEVEL) begin
                    ambient_q = i_cfg_data;
                end else begin
                    offset_q = i_cfg_data;
                end
            end
        end
    end

    // receiver: random stall per word, or a long hold when a test asks for one
    initial begin
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = rx_idle_en ? $urandom_range(0, 3) : 0;
            if (rx_hold_len > 0) begin
                stall       = rx_hold_len;
                rx_hold_len = 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // called and returns at a falling edge
    task automatic send_pair(input logic [7:0] right, input logic [7:0] left);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {left, right};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_reading();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 255);
            1: v = ambient_q + $urandom_range(0, 30);
            2: v = $urandom_range(0, ambient_q);
            default: v = FULL_SCALE - $urandom_range(0, 12);
        endcase
        return (v > FULL_SCALE) ? 8'hFF : 8'(v);
    endfunction

    task automatic send_random_pair();
        logic [7:0] right;
        logic [7:0] left_eff;
        right = pick_reading();
        if ($urandom_range(0, 2) == 0) begin
            left_eff = right + 8'($urandom_range(0, 24)) - 8'd12;
        end else begin
            left_eff = pick_reading();
        end
        // undo the offset so the corrected left reading lands where intended
        send_pair(right, left_eff - offset_q);
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (steer_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] ambient, input logic [7:0] offset);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= REG_AMBIENT_LEVEL;
        i_cfg_data  <= ambient;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_addr  <= REG_LEFT_OFFSET;
        i_cfg_data  <= offset;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        // registers still at reset: ambient 0, no offset
        send_pair(8'd0, 8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, 8'd255);
        send_pair(8'd19, 8'd19);
        send_pair(8'd20, 8'd0);
        send_pair(8'd100, 8'd91);
        send_pair(8'd100, 8'd90);
        send_pair(8'd90, 8'd100);
        send_pair(8'd91, 8'd100);
        send_pair(8'd200, 8'd100);
        send_pair(8'd100, 8'd200);
        wait_all_results();
        // left sum wraps past 255 before the clamp
        set_config(8'd100, 8'd200);
        send_pair(8'd50, 8'd100);
        send_pair(8'd200, 8'd60);
        send_pair(8'd100, 8'd160);
        send_pair(8'd130, 8'd180);
        wait_all_results();
        // ambient this high forces stop on every pair
        set_config(8'd236, 8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd255, 8'd236);
        wait_all_results();
        // smallest span that still lets the block move
        set_config(8'd235, 8'd0);
        send_pair(8'd255, 8'd235);
        send_pair(8'd255, 8'd240);
        wait_all_results();
        set_config(8'd255, 8'd255);
        send_pair(8'd0, 8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd255, 8'd1);
        wait_all_results();
    endtask

    task automatic test_config_sweep();
        logic [7:0] ambient;
        for (int phase = 0; phase < 13; phase++) begin
            tx_idle_en = (phase % 4) != 3;
            rx_idle_en = (phase % 4) != 2;
            ambient = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 110));
            wait_all_results();
            set_config(ambient, 8'($urandom_range(0, 255)));
            repeat (110) send_random_pair();
        end
        wait_all_results();
    endtask

    task automatic test_output_stall();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b1;
        set_config(8'($urandom_range(0, 60)), 8'($urandom_range(0, 255)));
        rx_hold_len = 250;
        repeat (60) send_random_pair();
        wait_all_results();
    endtask

    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_config(8'($urandom_range(0, 80)), 8'($urandom_range(0, 255)));
        repeat (150) send_random_pair();
        wait_all_results();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_addr  = REG_AMBIENT_LEVEL;
        i_cfg_data  = '0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        rx_hold_len = 0;
        fail_count  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_config_sweep();
        test_output_stall();
        test_full_rate();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
